// ===== hdl/qpsm_pkg.sv =====
// Package for the quadrature phase speed monitor.
// Holds the field widths, event codes and reset constants shared by all files.
// No dependencies.
package qpsm_pkg;

  localparam int TIME_W    = 32;
  localparam int NUM_W     = 32;
  localparam int SPEED_W   = 16;
  localparam int COUNT_W   = 16;
  localparam int MODE_W    = 2;

  localparam int DIGIT_W   = 2;
  localparam int SUB_STEPS = TIME_W / DIGIT_W;
  localparam int SUB_CNT_W = $clog2(SUB_STEPS);
  localparam int QUOT_CNT_W = $clog2(SPEED_W);

  typedef logic [MODE_W-1:0]  mode_t;
  typedef logic [TIME_W-1:0]  time_t;
  typedef logic [NUM_W-1:0]   num_t;
  typedef logic [SPEED_W-1:0] speed_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam mode_t MODE_RISE_A = 2'd0;
  localparam mode_t MODE_RISE_B = 2'd1;
  localparam mode_t MODE_CLEAR  = 2'd2;

  localparam num_t   NUM_RESET = 32'd60000000;
  localparam speed_t SPEED_MAX = 16'hFFFF;

endpackage

// ===== hdl/qpsm_chan_if.sv =====
// Valid/ready channel interfaces for the event input and the result output.
// Depends on qpsm_pkg for the payload types.
interface qpsm_in_if;
  logic              valid;
  logic              ready;
  qpsm_pkg::mode_t   mode;
  logic              other_level;
  qpsm_pkg::time_t   timestamp_us;

  modport source (output valid, mode, other_level, timestamp_us, input ready);
  modport sink   (input valid, mode, other_level, timestamp_us, output ready);
endinterface

interface qpsm_out_if;
  logic              valid;
  logic              ready;
  logic              direction_ccw;
  qpsm_pkg::time_t   phase_delta_us;
  qpsm_pkg::speed_t  speed_rpm;
  qpsm_pkg::count_t  rise_count;

  modport source (output valid, direction_ccw, phase_delta_us, speed_rpm, rise_count,
                  input ready);
  modport sink   (input valid, direction_ccw, phase_delta_us, speed_rpm, rise_count,
                  output ready);
endinterface

// ===== hdl/qpsm_sub_serial.sv =====
// Digit-serial subtractor: minuend minus subtrahend, two bits per cycle, LSB first.
// Depends on qpsm_pkg for widths.
module qpsm_sub_serial (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  qpsm_pkg::time_t minuend,
  input  qpsm_pkg::time_t subtrahend,
  output logic            done,
  output qpsm_pkg::time_t diff
);
  import qpsm_pkg::*;

  time_t                a_r, a_nxt;
  time_t                b_r, b_nxt;
  time_t                d_r, d_nxt;
  logic                 carry_r, carry_nxt;
  logic [SUB_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIGIT_W:0]     dsum;

  assign dsum = {1'b0, a_r[DIGIT_W-1:0]} + {1'b0, ~b_r[DIGIT_W-1:0]}
              + {{DIGIT_W{1'b0}}, carry_r};

  always_comb begin
    a_nxt     = a_r;
    b_nxt     = b_r;
    d_nxt     = d_r;
    carry_nxt = carry_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (start) begin
      a_nxt     = minuend;
      b_nxt     = subtrahend;
      carry_nxt = 1'b1;
      cnt_nxt   = '0;
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      a_nxt     = a_r >> DIGIT_W;
      b_nxt     = b_r >> DIGIT_W;
      d_nxt     = {dsum[DIGIT_W-1:0], d_r[TIME_W-1:DIGIT_W]};
      carry_nxt = dsum[DIGIT_W];
      cnt_nxt   = cnt_r + 1'b1;
      if (cnt_r == SUB_CNT_W'(SUB_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      cnt_r   <= '0;
      carry_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      cnt_r   <= cnt_nxt;
      carry_r <= carry_nxt;
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
    d_r <= d_nxt;
  end

  assign done = done_r;
  assign diff = d_r;

endmodule

// ===== hdl/qpsm_div_serial.sv =====
// Bit-serial restoring divider giving a 16-bit saturated quotient, one bit per cycle.
// A zero divisor gives zero. Depends on qpsm_pkg for widths and the saturation value.
module qpsm_div_serial (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  qpsm_pkg::num_t   num,
  input  qpsm_pkg::time_t  den,
  output logic             done,
  output qpsm_pkg::speed_t quot
);
  import qpsm_pkg::*;

  typedef enum logic [1:0] {D_IDLE, D_CHECK, D_ITER} div_state_t;

  div_state_t            state_r, state_nxt;
  time_t                 den_r, den_nxt;
  time_t                 rem_r, rem_nxt;
  speed_t                dvd_r, dvd_nxt;
  speed_t                quot_r, quot_nxt;
  logic [QUOT_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  done_r, done_nxt;
  logic [TIME_W:0]       trial;
  logic [TIME_W:0]       tdiff;

  assign trial = {rem_r, dvd_r[SPEED_W-1]};
  assign tdiff = trial - {1'b0, den_r};

  always_comb begin
    state_nxt = state_r;
    den_nxt   = den_r;
    rem_nxt   = rem_r;
    dvd_nxt   = dvd_r;
    quot_nxt  = quot_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      D_IDLE: begin
        if (start) begin
          den_nxt   = den;
          rem_nxt   = {{(TIME_W - (NUM_W - SPEED_W)){1'b0}}, num[NUM_W-1:SPEED_W]};
          dvd_nxt   = num[SPEED_W-1:0];
          state_nxt = D_CHECK;
        end
      end
      D_CHECK: begin
        cnt_nxt = '0;
        if (den_r == '0) begin
          quot_nxt  = '0;
          done_nxt  = 1'b1;
          state_nxt = D_IDLE;
        end else if (rem_r >= den_r) begin
          quot_nxt  = SPEED_MAX;
          done_nxt  = 1'b1;
          state_nxt = D_IDLE;
        end else begin
          state_nxt = D_ITER;
        end
      end
      D_ITER: begin
        dvd_nxt = dvd_r << 1;
        cnt_nxt = cnt_r + 1'b1;
        if (!tdiff[TIME_W]) begin
          rem_nxt  = tdiff[TIME_W-1:0];
          quot_nxt = {quot_r[SPEED_W-2:0], 1'b1};
        end else begin
          rem_nxt  = trial[TIME_W-1:0];
          quot_nxt = {quot_r[SPEED_W-2:0], 1'b0};
        end
        if (cnt_r == QUOT_CNT_W'(SPEED_W - 1)) begin
          done_nxt  = 1'b1;
          state_nxt = D_IDLE;
        end
      end
      default: state_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      cnt_r   <= cnt_nxt;
    end
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    dvd_r  <= dvd_nxt;
    quot_r <= quot_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// ===== hdl/quadrature_phase_speed_monitor.sv =====
// Quadrature phase speed monitor: edge events in, direction, delta, speed and count out.
// Depends on qpsm_pkg, qpsm_chan_if, qpsm_sub_serial and qpsm_div_serial.
//
// Usage: each transfer on in_ch is one event, a rising edge on channel A or B with
// the other channel's level and a microsecond timestamp, or a command that clears
// the rise count. Every event gives exactly one transfer on out_ch carrying the
// direction, phase delta, speed and rise count after the event.
// cfg_we with cfg_wdata writes the speed numerator; write it only while idle.
// The block works on one event at a time. A lagging edge runs the phase subtraction
// through a two-bit serial subtractor; every event then runs the divider (a check
// state, then the quotient-bit iterations, which are skipped when the delta is zero
// or the quotient saturates). in_ch.ready rises at the edge that loads the result
// into the output register, and no new event is taken before then.
// The result is held in an output register, so the next event is taken while a
// result waits; if out_ch stays stalled, the next result waits inside the block
// and in_ch.ready stays low until the output register is free.
// Reset (rst_n low, synchronous) clears all stored times, the delta, direction and
// count, and loads the numerator with 60000000.
module quadrature_phase_speed_monitor (
  input  logic             clk,
  input  logic             rst_n,
  qpsm_in_if.sink          in_ch,
  qpsm_out_if.source       out_ch,
  input  logic             cfg_we,
  input  qpsm_pkg::num_t   cfg_wdata
);
  import qpsm_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SUB, S_DIV, S_OUT} state_t;

  state_t state_r, state_nxt;
  num_t   numer_r, numer_nxt;
  time_t  a_rise_r, a_rise_nxt;
  time_t  b_rise_r, b_rise_nxt;
  time_t  delta_r, delta_nxt;
  logic   dir_r, dir_nxt;
  count_t count_r, count_nxt;
  logic   lag_a_r, lag_a_nxt;
  speed_t speed_r, speed_nxt;

  logic   out_valid_r, out_valid_nxt;
  logic   out_dir_r, out_dir_nxt;
  time_t  out_delta_r, out_delta_nxt;
  speed_t out_speed_r, out_speed_nxt;
  count_t out_count_r, out_count_nxt;

  logic   in_xfer;
  logic   out_load;
  logic   lag;
  logic   sub_start, sub_done;
  time_t  sub_subtrahend, sub_diff;
  logic   div_start, div_done;
  time_t  div_den;
  speed_t div_quot;

  assign in_xfer  = in_ch.valid && (state_r == S_IDLE);
  assign lag      = in_ch.other_level
                 && ((in_ch.mode == MODE_RISE_A) || (in_ch.mode == MODE_RISE_B));
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  assign sub_start      = in_xfer && lag;
  assign sub_subtrahend = (in_ch.mode == MODE_RISE_A) ? b_rise_r : a_rise_r;
  assign div_start      = (in_xfer && !lag) || ((state_r == S_SUB) && sub_done);
  assign div_den        = (state_r == S_SUB) ? sub_diff : delta_r;

  qpsm_sub_serial u_sub (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (sub_start),
    .minuend    (in_ch.timestamp_us),
    .subtrahend (sub_subtrahend),
    .done       (sub_done),
    .diff       (sub_diff)
  );

  qpsm_div_serial u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (numer_r),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    state_nxt     = state_r;
    numer_nxt     = cfg_we ? cfg_wdata : numer_r;
    a_rise_nxt    = a_rise_r;
    b_rise_nxt    = b_rise_r;
    delta_nxt     = delta_r;
    dir_nxt       = dir_r;
    count_nxt     = count_r;
    lag_a_nxt     = lag_a_r;
    speed_nxt     = speed_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_dir_nxt   = out_dir_r;
    out_delta_nxt = out_delta_r;
    out_speed_nxt = out_speed_r;
    out_count_nxt = out_count_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          lag_a_nxt = (in_ch.mode == MODE_RISE_A);
          if (lag) begin
            state_nxt = S_SUB;
          end else begin
            state_nxt = S_DIV;
            case (in_ch.mode)
              MODE_RISE_A: a_rise_nxt = in_ch.timestamp_us;
              MODE_RISE_B: b_rise_nxt = in_ch.timestamp_us;
              MODE_CLEAR:  count_nxt  = '0;
              default:     ;
            endcase
          end
        end
      end
      S_SUB: begin
        if (sub_done) begin
          delta_nxt = sub_diff;
          dir_nxt   = !lag_a_r;
          if (lag_a_r) begin
            count_nxt = count_r + 1'b1;
          end
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          speed_nxt = div_quot;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_dir_nxt   = dir_r;
          out_delta_nxt = delta_r;
          out_speed_nxt = speed_r;
          out_count_nxt = count_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      numer_r     <= NUM_RESET;
      a_rise_r    <= '0;
      b_rise_r    <= '0;
      delta_r     <= '0;
      dir_r       <= 1'b0;
      count_r     <= '0;
      lag_a_r     <= 1'b0;
      speed_r     <= '0;
      out_valid_r <= 1'b0;
      out_dir_r   <= 1'b0;
      out_delta_r <= '0;
      out_speed_r <= '0;
      out_count_r <= '0;
    end else begin
      state_r     <= state_nxt;
      numer_r     <= numer_nxt;
      a_rise_r    <= a_rise_nxt;
      b_rise_r    <= b_rise_nxt;
      delta_r     <= delta_nxt;
      dir_r       <= dir_nxt;
      count_r     <= count_nxt;
      lag_a_r     <= lag_a_nxt;
      speed_r     <= speed_nxt;
      out_valid_r <= out_valid_nxt;
      out_dir_r   <= out_dir_nxt;
      out_delta_r <= out_delta_nxt;
      out_speed_r <= out_speed_nxt;
      out_count_r <= out_count_nxt;
    end
  end

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.direction_ccw  = out_dir_r;
  assign out_ch.phase_delta_us = out_delta_r;
  assign out_ch.speed_rpm      = out_speed_r;
  assign out_ch.rise_count     = out_count_r;

  a_sub_done_in_sub: assert property (@(posedge clk) disable iff (!rst_n)
    sub_done |-> state_r == S_SUB)
    else $error("subtractor finished outside the subtraction state");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside the division state");

  a_xfer_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> state_r != S_IDLE)
    else $error("accepted event did not start processing");

  a_zero_delta_speed: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_ch.phase_delta_us != '0 || out_ch.speed_rpm == '0))
    else $error("non-zero speed reported for zero phase delta");

endmodule

// ===== test/speed_monitor_checker.sv =====
`timescale 1ns / 100ps
// Checker for the quadrature phase speed monitor: watches the event, result and numerator ports,
// predicts every result and compares it field by field. Depends on qpsm_pkg and qpsm_chan_if.
module speed_monitor_checker (
  input  logic             clk,
  input  logic             rst_n,
  qpsm_in_if               in_ch,
  qpsm_out_if              out_ch,
  input  logic             cfg_we,
  input  qpsm_pkg::num_t   cfg_wdata,
  output int               mismatches,
  output int               pending
);
  import qpsm_pkg::*;

  typedef struct packed {
    logic   ccw;
    time_t  lag;
    speed_t rpm;
    count_t laps;
  } speed_report_t;

  num_t   numerator = NUM_RESET;
  time_t  last_a_rise = '0;
  time_t  last_b_rise = '0;
  time_t  lag_us = '0;
  logic   ccw = 1'b0;
  count_t lag_count = '0;
  int     err_total = 0;

  speed_report_t awaited_reports[$];

  assign mismatches = err_total;

  function automatic speed_t rpm_from_lag(num_t num, time_t lag);
    num_t quotient;
    if (lag == '0) return '0;
    quotient = num / lag;
    return (quotient > num_t'(SPEED_MAX)) ? SPEED_MAX : quotient[SPEED_W-1:0];
  endfunction

  task automatic apply_edge_event(input mode_t mode, input logic other_high, input time_t ts,
                                  output speed_report_t rep);
    case (mode)
      MODE_RISE_A: begin
        if (other_high) begin
          lag_us = ts - last_b_rise;
          ccw = 1'b0;
          lag_count = lag_count + 1'b1;
        end else begin
          last_a_rise = ts;
        end
      end
      MODE_RISE_B: begin
        if (other_high) begin
          lag_us = ts - last_a_rise;
          ccw = 1'b1;
        end else begin
          last_b_rise = ts;
        end
      end
      MODE_CLEAR: lag_count = '0;
      default: ;
    endcase
    rep.ccw = ccw;
    rep.lag = lag_us;
    rep.rpm = rpm_from_lag(numerator, lag_us);
    rep.laps = lag_count;
  endtask

  task automatic report_error(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    err_total++;
  endtask

  always @(posedge clk) begin
    speed_report_t want;
    if (!rst_n) begin
      numerator = NUM_RESET;
      last_a_rise = '0;
      last_b_rise = '0;
      lag_us = '0;
      ccw = 1'b0;
      lag_count = '0;
      awaited_reports.delete();
    end else begin
      if (cfg_we) numerator = cfg_wdata;
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_reports.size() == 0) begin
          report_error("result transfer with no event outstanding");
        end else begin
          want = awaited_reports.pop_front();
          if (out_ch.direction_ccw !== want.ccw)
            report_error($sformatf("direction_ccw %b, expected %b", out_ch.direction_ccw,
                                   want.ccw));
          if (out_ch.phase_delta_us !== want.lag)
            report_error($sformatf("phase_delta_us %h, expected %h", out_ch.phase_delta_us,
                                   want.lag));
          if (out_ch.speed_rpm !== want.rpm)
            report_error($sformatf("speed_rpm %0d, expected %0d", out_ch.speed_rpm, want.rpm));
          if (out_ch.rise_count !== want.laps)
            report_error($sformatf("rise_count %0d, expected %0d", out_ch.rise_count,
                                   want.laps));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        apply_edge_event(in_ch.mode, in_ch.other_level, in_ch.timestamp_us, want);
        awaited_reports.push_back(want);
      end
    end
    pending <= awaited_reports.size();
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Top level of the quadrature phase speed monitor testbench: clock, reset, event stimulus,
// numerator writes, result back-pressure and the verdict. Depends on qpsm_pkg, qpsm_chan_if,
// the block itself and speed_monitor_checker.
module testbench;
  import qpsm_pkg::*;

  localparam mode_t MODE_UNUSED     = 2'd3;
  localparam int    STALL_LIMIT     = 5000;
  localparam int    ITEMS_PER_PHASE = 600;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  cfg_we;
  num_t  cfg_wdata;
  int    mismatches;
  int    pending;
  int    send_idle = 27;
  int    recv_idle = 86;
  int    quiet_cycles = 0;
  time_t clock_us;

  qpsm_in_if  in_ch ();
  qpsm_out_if out_ch ();

  quadrature_phase_speed_monitor uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  speed_monitor_checker speed_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_event(input mode_t mode, input logic other_high, input time_t ts);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.other_level <= other_high;
    in_ch.timestamp_us <= ts;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_numerator(input num_t value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic time_t pick_gap();
    case ($urandom_range(9))
      0: return '0;
      1: return $urandom();
      2, 3: return $urandom_range(1, 64);
      default: return $urandom_range(65, 200000);
    endcase
  endfunction

  // One quadrature step: the leading channel rises with the other low, then the
  // lagging channel rises with the other already high.
  task automatic quadrature_step(input logic turn_ccw, input time_t gap);
    clock_us += $urandom_range(0, 5000);
    send_event(turn_ccw ? MODE_RISE_A : MODE_RISE_B, 1'b0, clock_us);
    clock_us += gap;
    send_event(turn_ccw ? MODE_RISE_B : MODE_RISE_A, 1'b1, clock_us);
  endtask

  task automatic run_random(input int items);
    int sent;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(19))
        0: begin
          send_event(MODE_CLEAR, 1'($urandom_range(1)), $urandom());
          sent += 1;
        end
        1: begin
          send_event(MODE_UNUSED, 1'($urandom_range(1)), $urandom());
          sent += 1;
        end
        2, 3: begin
          send_event(mode_t'($urandom_range(3)), 1'($urandom_range(1)), $urandom());
          sent += 1;
        end
        default: begin
          quadrature_step(1'($urandom_range(1)), pick_gap());
          sent += 2;
        end
      endcase
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_RISE_A;
    in_ch.other_level = 1'b0;
    in_ch.timestamp_us = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    clock_us = $urandom();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_event(MODE_RISE_A, 1'b1, 32'd0);
    send_event(MODE_RISE_B, 1'b1, 32'd100);
    send_event(MODE_RISE_A, 1'b0, 32'd1000);
    send_event(MODE_RISE_B, 1'b1, 32'd61000);
    send_event(MODE_RISE_B, 1'b0, 32'hFFFF_FF00);
    send_event(MODE_RISE_A, 1'b1, 32'h0000_0100);
    send_event(MODE_RISE_B, 1'b0, 32'd1);
    send_event(MODE_RISE_A, 1'b1, 32'd0);
    send_event(MODE_UNUSED, 1'b1, 32'hFFFF_FFFF);
    send_event(MODE_CLEAR, 1'b1, 32'hFFFF_FFFF);
    send_event(MODE_RISE_A, 1'b0, 32'hFFFF_FFFF);
    send_event(MODE_RISE_B, 1'b1, 32'hFFFF_FFFF);

    write_numerator(32'd1);
    send_event(MODE_RISE_A, 1'b0, 32'd10);
    send_event(MODE_RISE_B, 1'b1, 32'd11);
    send_event(MODE_RISE_B, 1'b1, 32'd12);

    write_numerator(32'hFFFF_FFFF);
    send_event(MODE_RISE_B, 1'b0, 32'd0);
    send_event(MODE_RISE_A, 1'b1, 32'd65536);
    send_event(MODE_RISE_A, 1'b1, 32'd65538);
    send_event(MODE_RISE_B, 1'b1, 32'd3);
    send_event(MODE_CLEAR, 1'b0, 32'd0);

    write_numerator(($urandom() % 32'hFFFF_FFFF) + 1);
    run_random(ITEMS_PER_PHASE);

    write_numerator($urandom_range(1, 2000000));
    send_idle = 86;
    recv_idle = 27;
    run_random(ITEMS_PER_PHASE);

    write_numerator(NUM_RESET);
    send_idle = 0;
    recv_idle = 0;
    run_random(ITEMS_PER_PHASE);

    drain();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
